@@ hw/rtl/suffix_automaton_substring_matcher_top_assert.svh @@
// assertion macros for the substring matcher
`ifndef SUFFIX_AUTOMATON_SUBSTRING_MATCHER_TOP_ASSERT_SVH
`define SUFFIX_AUTOMATON_SUBSTRING_MATCHER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define SAM_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define SAM_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define SAM_ASSERT_IMP(lbl, a, b)
`define SAM_ASSERT_NEXT(lbl, a, b)
`endif

`endif

@@ hw/rtl/sam_pkg.sv @@
package sam_pkg;

    localparam int LETTER_W   = 5;
    localparam int ALPHABET   = 26;
    localparam int STATE_W    = 12;
    localparam int CNT_W      = 13;
    localparam int LEN_W      = 12;
    localparam int MAX_STATES = 4096;
    localparam int TRANS_AW   = STATE_W + LETTER_W;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_CHK,
        ST_QCHK,
        ST_COPY,
        ST_RD2,
        ST_CHK2,
        ST_MRD,
        ST_MCHK,
        ST_DONE
    } sam_state_t;

    typedef struct packed {
        logic                status;
        logic [LEN_W-1:0]    match_len;
        logic [LEN_W-1:0]    best_len;
    } sam_res_t;

    typedef struct packed {
        logic                we;
        logic [TRANS_AW-1:0] waddr;
        logic [STATE_W-1:0]  wdata;
        logic [TRANS_AW-1:0] raddr;
    } sam_treq_t;

    // one entry per state: suffix link and longest length
    typedef struct packed {
        logic [STATE_W-1:0]  link;
        logic [LEN_W-1:0]    len;
    } sam_node_t;

    typedef struct packed {
        logic                we;
        logic [STATE_W-1:0]  waddr;
        sam_node_t           wdata;
        logic [STATE_W-1:0]  raddr;
    } sam_nreq_t;

endpackage

@@ hw/rtl/sam_ram.sv @@
module sam_ram #(
    parameter int AW = 12,
    parameter int DW = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/sam_ctrl.sv @@
module sam_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_kind,
    input  logic [sam_pkg::LETTER_W-1:0]      in_letter,
    output logic                              in_ready,
    output logic                              res_valid,
    input  logic                              res_ready,
    output sam_pkg::sam_res_t                 res,
    output sam_pkg::sam_treq_t                trans_req,
    output sam_pkg::sam_nreq_t                node_req,
    input  logic [sam_pkg::STATE_W-1:0]       trans_rd,
    input  sam_pkg::sam_node_t                node_rd
);

    localparam logic [sam_pkg::LETTER_W-1:0] ALPHA_L = sam_pkg::LETTER_W'(sam_pkg::ALPHABET);
    localparam logic [sam_pkg::CNT_W:0]      MAX_C   = (sam_pkg::CNT_W+1)'(sam_pkg::MAX_STATES);

    sam_pkg::sam_state_t state_reg, state_next;

    logic [sam_pkg::STATE_W-1:0]  p_reg, p_next, q_reg, q_next;
    logic [sam_pkg::STATE_W-1:0]  fresh_reg, fresh_next, twin_reg, twin_next;
    logic [sam_pkg::STATE_W-1:0]  last_reg, last_next, cur_reg, cur_next;
    logic [sam_pkg::LETTER_W-1:0] letter_reg, letter_next;
    logic [sam_pkg::LEN_W-1:0]    lenp1_reg, lenp1_next, clen_reg, clen_next;
    logic [sam_pkg::LEN_W-1:0]    lenf_reg, lenf_next, qlen_reg, qlen_next;
    logic [sam_pkg::LEN_W-1:0]    best_reg, best_next;
    logic [sam_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                         first_reg, first_next, fb_reg, fb_next;
    logic [sam_pkg::LETTER_W-1:0] k_reg, k_next;
    logic [sam_pkg::TRANS_AW-1:0] clr_reg, clr_next;
    sam_pkg::sam_res_t            res_reg, res_next;

    logic                         full;
    logic                         bad_letter;
    logic [sam_pkg::STATE_W-1:0]  link_rd;
    logic [sam_pkg::LEN_W-1:0]    len_rd;
    logic [sam_pkg::LEN_W-1:0]    eff_len;
    logic [sam_pkg::LEN_W-1:0]    inc_len;
    logic [sam_pkg::LETTER_W-1:0] k_prev;

    assign link_rd    = node_rd.link;
    assign len_rd     = node_rd.len;
    assign full       = ({1'b0, cnt_reg} + (sam_pkg::CNT_W+1)'(2)) > MAX_C;
    assign bad_letter = in_letter >= ALPHA_L;
    assign eff_len    = fb_reg ? len_rd : clen_reg;
    assign inc_len    = eff_len + sam_pkg::LEN_W'(1);
    assign k_prev     = k_reg - sam_pkg::LETTER_W'(1);
    assign in_ready   = (state_reg == sam_pkg::ST_IDLE);
    assign res_valid  = (state_reg == sam_pkg::ST_DONE);
    assign res        = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sam_pkg::ST_CLR;
            clr_reg   <= '0;
            cnt_reg   <= sam_pkg::CNT_W'(1);
            last_reg  <= '0;
            cur_reg   <= '0;
            clen_reg  <= '0;
            best_reg  <= '0;
            first_reg <= 1'b0;
            fb_reg    <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            cur_reg   <= cur_next;
            clen_reg  <= clen_next;
            best_reg  <= best_next;
            first_reg <= first_next;
            fb_reg    <= fb_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        q_reg      <= q_next;
        fresh_reg  <= fresh_next;
        twin_reg   <= twin_next;
        letter_reg <= letter_next;
        lenp1_reg  <= lenp1_next;
        lenf_reg   <= lenf_next;
        qlen_reg   <= qlen_next;
        res_reg    <= res_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sam_pkg::ST_CLR:
            begin
                if (&clr_reg)
                begin
                    state_next = sam_pkg::ST_IDLE;
                end
            end
            sam_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!in_kind)
                    begin
                        state_next = (full || bad_letter) ? sam_pkg::ST_DONE
                                                          : sam_pkg::ST_RD;
                    end
                    else
                    begin
                        state_next = bad_letter ? sam_pkg::ST_DONE : sam_pkg::ST_MRD;
                    end
                end
            end
            sam_pkg::ST_RD:   state_next = sam_pkg::ST_CHK;
            sam_pkg::ST_CHK:
            begin
                priority if (trans_rd == '0)
                    state_next = sam_pkg::ST_RD;
                else if (trans_rd == fresh_reg)
                    state_next = sam_pkg::ST_DONE;
                else
                    state_next = sam_pkg::ST_QCHK;
            end
            sam_pkg::ST_QCHK:
            begin
                state_next = (len_rd == lenp1_reg) ? sam_pkg::ST_DONE : sam_pkg::ST_COPY;
            end
            sam_pkg::ST_COPY:
            begin
                if (k_reg == ALPHA_L)
                begin
                    state_next = sam_pkg::ST_RD2;
                end
            end
            sam_pkg::ST_RD2:  state_next = sam_pkg::ST_CHK2;
            sam_pkg::ST_CHK2:
            begin
                state_next = (trans_rd == q_reg) ? sam_pkg::ST_RD2 : sam_pkg::ST_DONE;
            end
            sam_pkg::ST_MRD:  state_next = sam_pkg::ST_MCHK;
            sam_pkg::ST_MCHK:
            begin
                state_next = (cur_reg != '0 && trans_rd == '0) ? sam_pkg::ST_MRD
                                                               : sam_pkg::ST_DONE;
            end
            sam_pkg::ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = sam_pkg::ST_IDLE;
                end
            end
            default: state_next = sam_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory ports
    always_comb
    begin
        p_next      = p_reg;
        q_next      = q_reg;
        fresh_next  = fresh_reg;
        twin_next   = twin_reg;
        letter_next = letter_reg;
        lenp1_next  = lenp1_reg;
        lenf_next   = lenf_reg;
        qlen_next   = qlen_reg;
        res_next    = res_reg;
        clr_next    = clr_reg;
        cnt_next    = cnt_reg;
        last_next   = last_reg;
        cur_next    = cur_reg;
        clen_next   = clen_reg;
        best_next   = best_reg;
        first_next  = first_reg;
        fb_next     = fb_reg;
        k_next      = k_reg;

        trans_req       = '0;
        node_req        = '0;
        trans_req.raddr = {p_reg, letter_reg};
        node_req.raddr  = p_reg;

        unique case (state_reg)
            sam_pkg::ST_CLR:
            begin
                trans_req.we    = 1'b1;
                trans_req.waddr = clr_reg;
                node_req.we     = (clr_reg[sam_pkg::TRANS_AW-1:sam_pkg::STATE_W] == '0);
                node_req.waddr  = clr_reg[sam_pkg::STATE_W-1:0];
                clr_next        = clr_reg + sam_pkg::TRANS_AW'(1);
            end
            sam_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    letter_next = in_letter;
                    if (!in_kind)
                    begin
                        if (full)
                        begin
                            res_next = '{status: 1'b1, match_len: clen_reg,
                                         best_len: best_reg};
                        end
                        else
                        begin
                            res_next   = '0;
                            cur_next   = '0;
                            clen_next  = '0;
                            best_next  = '0;
                            if (!bad_letter)
                            begin
                                p_next     = last_reg;
                                fresh_next = cnt_reg[sam_pkg::STATE_W-1:0];
                                last_next  = cnt_reg[sam_pkg::STATE_W-1:0];
                                cnt_next   = cnt_reg + sam_pkg::CNT_W'(1);
                                first_next = 1'b1;
                            end
                        end
                    end
                    else if (bad_letter)
                    begin
                        cur_next  = '0;
                        clen_next = '0;
                        res_next  = '{status: 1'b0, match_len: '0, best_len: best_reg};
                    end
                    else
                    begin
                        fb_next = 1'b0;
                    end
                end
            end
            sam_pkg::ST_RD:
            begin
            end
            sam_pkg::ST_CHK:
            begin
                first_next = 1'b0;
                // length of the new state comes from the last state, written with its link
                if (first_reg)
                begin
                    lenf_next = len_rd + sam_pkg::LEN_W'(1);
                end
                priority if (trans_rd == '0)
                begin
                    trans_req.we    = 1'b1;
                    trans_req.waddr = {p_reg, letter_reg};
                    trans_req.wdata = fresh_reg;
                    p_next          = link_rd;
                end
                else if (trans_rd == fresh_reg)
                begin
                    node_req.we    = 1'b1;
                    node_req.waddr = fresh_reg;
                    node_req.wdata = '{link: '0, len: lenf_reg};
                end
                else
                begin
                    q_next         = trans_rd;
                    lenp1_next     = len_rd + sam_pkg::LEN_W'(1);
                    node_req.raddr = trans_rd;
                end
            end
            sam_pkg::ST_QCHK:
            begin
                if (len_rd == lenp1_reg)
                begin
                    node_req.we    = 1'b1;
                    node_req.waddr = fresh_reg;
                    node_req.wdata = '{link: q_reg, len: lenf_reg};
                end
                else
                begin
                    // clone takes the link and a shorter length
                    twin_next      = cnt_reg[sam_pkg::STATE_W-1:0];
                    cnt_next       = cnt_reg + sam_pkg::CNT_W'(1);
                    qlen_next      = len_rd;
                    node_req.we    = 1'b1;
                    node_req.waddr = cnt_reg[sam_pkg::STATE_W-1:0];
                    node_req.wdata = '{link: link_rd, len: lenp1_reg};
                    k_next         = '0;
                end
            end
            sam_pkg::ST_COPY:
            begin
                // row copy: read entry k of q, write entry k-1 of the clone
                trans_req.raddr = {q_reg, k_reg};
                trans_req.we    = (k_reg != '0);
                trans_req.waddr = {twin_reg, k_prev};
                trans_req.wdata = trans_rd;
                node_req.we     = (k_reg == '0) || (k_reg == sam_pkg::LETTER_W'(1));
                if (k_reg == '0)
                begin
                    node_req.waddr = fresh_reg;
                    node_req.wdata = '{link: twin_reg, len: lenf_reg};
                end
                else
                begin
                    node_req.waddr = q_reg;
                    node_req.wdata = '{link: twin_reg, len: qlen_reg};
                end
                k_next          = k_reg + sam_pkg::LETTER_W'(1);
            end
            sam_pkg::ST_RD2:
            begin
            end
            sam_pkg::ST_CHK2:
            begin
                if (trans_rd == q_reg)
                begin
                    trans_req.we    = 1'b1;
                    trans_req.waddr = {p_reg, letter_reg};
                    trans_req.wdata = twin_reg;
                    p_next          = link_rd;
                end
            end
            sam_pkg::ST_MRD:
            begin
                trans_req.raddr = {cur_reg, letter_reg};
                node_req.raddr  = cur_reg;
            end
            sam_pkg::ST_MCHK:
            begin
                priority if (cur_reg != '0 && trans_rd == '0)
                begin
                    cur_next = link_rd;
                    fb_next  = 1'b1;
                end
                else if (trans_rd != '0)
                begin
                    cur_next  = trans_rd;
                    clen_next = inc_len;
                    best_next = (inc_len > best_reg) ? inc_len : best_reg;
                    res_next  = '{status: 1'b0, match_len: inc_len,
                                  best_len: (inc_len > best_reg) ? inc_len : best_reg};
                end
                else
                begin
                    clen_next = eff_len;
                    res_next  = '{status: 1'b0, match_len: eff_len, best_len: best_reg};
                end
            end
            sam_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ hw/rtl/suffix_automaton_substring_matcher_top.sv @@
// suffix automaton matcher: build letters (s_tuser low) extend an automaton of the text,
// match letters (s_tuser high) walk a cursor over it; every input transfer gives one output
// transfer with the current match length and the best length so far. all state sits in
// two rams (transitions, and one entry per state holding suffix link and length) and one
// controller steps through them. after reset a clearing pass zeroes the rams and s_tready
// stays low meanwhile. the time from taking a letter until s_tready is high again grows with
// each suffix-link fallback for a match letter; for a build letter it grows with each link
// step on the walk and with the check of the edge target's length, and a clone adds a row
// copy, a step per edge redirected to it and a step to end that walk; letters out of the
// alphabet and build letters with the store full go straight to the result. the cost is set
// by the one-read-per-cycle rams. the next item is taken while a result still waits in the
// output register. status (m_tuser) high means the state store is full and the build letter
// was dropped.
`include "suffix_automaton_substring_matcher_top_assert.svh"

module suffix_automaton_substring_matcher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // letter [4:0], zero fill [7:5]
    input  logic        s_tuser,    // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // match_len [11:0], best_len [23:12]
    output logic        m_tuser     // status
);

    sam_pkg::sam_treq_t          trans_req;
    sam_pkg::sam_nreq_t          node_req;
    logic [sam_pkg::STATE_W-1:0] trans_rd;
    sam_pkg::sam_node_t          node_rd;
    sam_pkg::sam_res_t           res;
    logic                        res_valid;
    logic                        res_ready;
    logic                        m_tvalid_reg;
    sam_pkg::sam_res_t           out_reg;

    // the output register frees the controller as soon as its result is parked
    assign res_ready = !m_tvalid_reg || m_tready;

    sam_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_kind   (s_tuser),
        .in_letter (s_tdata[sam_pkg::LETTER_W-1:0]),
        .in_ready  (s_tready),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .trans_req (trans_req),
        .node_req  (node_req),
        .trans_rd  (trans_rd),
        .node_rd   (node_rd)
    );

    // transitions, row stride of 32 letters
    sam_ram #(.AW(sam_pkg::TRANS_AW), .DW(sam_pkg::STATE_W)) u_trans (
        .clk   (clk),
        .we    (trans_req.we),
        .waddr (trans_req.waddr),
        .wdata (trans_req.wdata),
        .raddr (trans_req.raddr),
        .rdata (trans_rd)
    );

    // suffix link and longest length per state
    sam_ram #(.AW(sam_pkg::STATE_W), .DW(sam_pkg::STATE_W + sam_pkg::LEN_W)) u_node (
        .clk   (clk),
        .we    (node_req.we),
        .waddr (node_req.waddr),
        .wdata (node_req.wdata),
        .raddr (node_req.raddr),
        .rdata (node_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {out_reg.best_len, out_reg.match_len};

    // a new item is only taken with no transfer in flight in the controller
    `SAM_ASSERT_IMP(a_ready_only_idle, s_tready, !res_valid)
    // a parked result shows up at the output on the next cycle
    `SAM_ASSERT_NEXT(a_result_lands, res_valid && res_ready, m_tvalid)
    // best length never falls below the current match length
    `SAM_ASSERT_IMP(a_best_covers_match, m_tvalid, m_tdata[23:12] >= m_tdata[11:0])

endmodule

@@ test/sam_tb_pkg.sv @@
`timescale 1ns / 1ps

package sam_tb_pkg;

    // s_tuser values
    localparam bit KIND_BUILD = 1'b0;
    localparam bit KIND_MATCH = 1'b1;

    // m_tuser values
    localparam bit STATUS_OK   = 1'b0;
    localparam bit STATUS_FULL = 1'b1;

endpackage

@@ test/sam_checker.sv @@
`timescale 1ns / 1ps

module sam_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser,
    output int          errors,
    output int          waiting
);

    // own copy of the automaton
    logic [sam_pkg::STATE_W-1:0] edge_to [sam_pkg::MAX_STATES*sam_pkg::ALPHABET];
    int unsigned        link_of [sam_pkg::MAX_STATES];
    int unsigned        len_of  [sam_pkg::MAX_STATES];
    int unsigned        tail_state;
    int unsigned        n_states;
    int unsigned        cur_state;
    int unsigned        run_len;
    int unsigned        best_run;

    sam_pkg::sam_res_t  expected_results[$];

    initial
    begin
        errors  = 0;
        waiting = 0;
        foreach (edge_to[i])
            edge_to[i] = '0;
        foreach (link_of[i])
        begin
            link_of[i] = 0;
            len_of[i]  = 0;
        end
        tail_state = 0;
        n_states   = 1;
        cur_state  = 0;
        run_len    = 0;
        best_run   = 0;
    end

    function automatic int unsigned slot(input int unsigned s, input int unsigned c);
        return s * sam_pkg::ALPHABET + c;
    endfunction

    task automatic append_letter(input int unsigned c);
        int unsigned p;
        int unsigned fresh;
        int unsigned q;
        int unsigned twin;
        p          = tail_state;
        fresh      = n_states;
        n_states   = n_states + 1;
        tail_state = fresh;
        len_of[fresh] = len_of[p] + 1;
        while (edge_to[slot(p, c)] == 0)
        begin
            edge_to[slot(p, c)] = sam_pkg::STATE_W'(fresh);
            p = link_of[p];
        end
        if (edge_to[slot(p, c)] == fresh)
        begin
            link_of[fresh] = 0;
            return;
        end
        q = edge_to[slot(p, c)];
        if (len_of[q] == len_of[p] + 1)
        begin
            link_of[fresh] = q;
            return;
        end
        // split q into a shorter clone
        twin     = n_states;
        n_states = n_states + 1;
        for (int a = 0; a < sam_pkg::ALPHABET; a++)
            edge_to[slot(twin, a)] = edge_to[slot(q, a)];
        link_of[twin]  = link_of[q];
        len_of[twin]   = len_of[p] + 1;
        link_of[fresh] = twin;
        link_of[q]     = twin;
        while (edge_to[slot(p, c)] == q)
        begin
            edge_to[slot(p, c)] = sam_pkg::STATE_W'(twin);
            p = link_of[p];
        end
    endtask

    task automatic predict_letter(input bit kind, input int unsigned letter,
                                  output sam_pkg::sam_res_t r);
        r.status = sam_tb_pkg::STATUS_OK;
        if (kind == sam_tb_pkg::KIND_BUILD)
        begin
            if (n_states + 2 > sam_pkg::MAX_STATES)
                r.status = sam_tb_pkg::STATUS_FULL;
            else
            begin
                if (letter < sam_pkg::ALPHABET)
                    append_letter(letter);
                cur_state = 0;
                run_len   = 0;
                best_run  = 0;
            end
        end
        else if (letter >= sam_pkg::ALPHABET)
        begin
            cur_state = 0;
            run_len   = 0;
        end
        else
        begin
            // fall back along suffix links until an edge exists
            while (cur_state != 0 && edge_to[slot(cur_state, letter)] == 0)
            begin
                cur_state = link_of[cur_state];
                run_len   = len_of[cur_state];
            end
            if (edge_to[slot(cur_state, letter)] != 0)
            begin
                cur_state = edge_to[slot(cur_state, letter)];
                run_len   = run_len + 1;
                if (run_len > best_run)
                    best_run = run_len;
            end
        end
        r.match_len = run_len[sam_pkg::LEN_W-1:0];
        r.best_len  = best_run[sam_pkg::LEN_W-1:0];
    endtask

    always @(posedge clk)
    begin
        sam_pkg::sam_res_t want;
        sam_pkg::sam_res_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_letter(s_tuser, s_tdata[4:0], want);
                expected_results.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got.status    = m_tuser;
                got.match_len = m_tdata[11:0];
                got.best_len  = m_tdata[23:12];
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result transfer %h", $time, got);
                    errors = errors + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        errors = errors + 1;
                    end
                    if (got.match_len !== want.match_len)
                    begin
                        $display("%0t: match_len expected %0d actual %0d",
                                 $time, want.match_len, got.match_len);
                        errors = errors + 1;
                    end
                    if (got.best_len !== want.best_len)
                    begin
                        $display("%0t: best_len expected %0d actual %0d",
                                 $time, want.best_len, got.best_len);
                        errors = errors + 1;
                    end
                end
            end
            waiting = expected_results.size();
        end
    end

endmodule

@@ test/tb_suffix_automaton_substring_matcher_top.sv @@
`timescale 1ns / 1ps

module tb_suffix_automaton_substring_matcher_top;

    // clearing pass plus the letters with stalls on both sides
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int RANDOM_ITEMS  = 1430;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // letter [4:0], zero fill [7:5]
    logic        s_tuser;    // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;    // match_len [11:0], best_len [23:12]
    logic        m_tuser;    // status

    int          errors;
    int          waiting;
    int          cycles;
    int          sent;
    bit          idle_on;     // sender gaps enabled
    bit          stall_on;    // receiver stalls enabled
    int          stall_left;
    bit [4:0]    built_text[$];    // build letters sent so far, for matching runs

    suffix_automaton_substring_matcher_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sam_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .waiting  (waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles = cycles + 1;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("tb_suffix_automaton_substring_matcher_top: FAIL");
                $finish;
            end
        end
    end

    // receiver: a fresh random stall after each result transfer while stalls are enabled
    initial
    begin
        m_tready   = 1'b0;
        stall_left = 0;
        stall_on   = 1'b1;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                stall_left = stall_on ? $urandom_range(0, 15) : 0;
            else if (stall_left > 0)
                stall_left = stall_left - 1;
            m_tready <= rst_n && (stall_left == 0);
        end
    end

    // one input transfer; valid stays high across back-to-back items when no idle gap is drawn
    task automatic send_letter(input bit kind, input bit [4:0] letter);
        int gap;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, letter};
        do
            @(posedge clk);
        while (!s_tready);
        if (kind == sam_tb_pkg::KIND_BUILD && letter < sam_pkg::ALPHABET)
            built_text.push_back(letter);
        sent = sent + 1;
        // swap idle modes now and then so some stretches run flat out
        if (sent % 97 == 0)
        begin
            idle_on  = $urandom_range(0, 2) != 0;
            stall_on = $urandom_range(0, 2) != 0;
        end
    endtask

    task automatic build_run(input int n, input int span);
        for (int i = 0; i < n; i++)
            send_letter(sam_tb_pkg::KIND_BUILD, 5'($urandom_range(0, span - 1)));
    endtask

    // follow a stretch of the built text, sometimes with a wrong letter
    task automatic match_run(input int n);
        int start;
        bit [4:0] c;
        start = (built_text.size() > 0) ? $urandom_range(0, built_text.size() - 1) : 0;
        for (int i = 0; i < n; i++)
        begin
            if (built_text.size() == 0 || $urandom_range(0, 19) == 0)
                c = 5'($urandom_range(0, sam_pkg::ALPHABET - 1));
            else
                c = built_text[(start + i) % built_text.size()];
            send_letter(sam_tb_pkg::KIND_MATCH, c);
        end
    endtask

    initial
    begin
        int r;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = sam_tb_pkg::KIND_BUILD;
        sent     = 0;
        idle_on  = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty automaton, repeats that force clones, range edges
        send_letter(sam_tb_pkg::KIND_MATCH, 5'd0);
        send_letter(sam_tb_pkg::KIND_BUILD, 5'd0);
        send_letter(sam_tb_pkg::KIND_BUILD, 5'd1);
        send_letter(sam_tb_pkg::KIND_BUILD, 5'd0);
        send_letter(sam_tb_pkg::KIND_BUILD, 5'd1);
        send_letter(sam_tb_pkg::KIND_BUILD, 5'd1);
        send_letter(sam_tb_pkg::KIND_BUILD, 5'd0);
        send_letter(sam_tb_pkg::KIND_MATCH, 5'd0);
        send_letter(sam_tb_pkg::KIND_MATCH, 5'd1);
        send_letter(sam_tb_pkg::KIND_MATCH, 5'd1);
        send_letter(sam_tb_pkg::KIND_MATCH, 5'd0);
        send_letter(sam_tb_pkg::KIND_MATCH, 5'd25);    // no edge even at the root
        send_letter(sam_tb_pkg::KIND_MATCH, 5'd0);
        send_letter(sam_tb_pkg::KIND_MATCH, 5'd31);    // out of alphabet match
        send_letter(sam_tb_pkg::KIND_MATCH, 5'd1);
        send_letter(sam_tb_pkg::KIND_MATCH, 5'd26);
        send_letter(sam_tb_pkg::KIND_BUILD, 5'd31);    // out of alphabet build clears match
        send_letter(sam_tb_pkg::KIND_MATCH, 5'd0);
        send_letter(sam_tb_pkg::KIND_BUILD, 5'd26);
        send_letter(sam_tb_pkg::KIND_BUILD, 5'd25);
        send_letter(sam_tb_pkg::KIND_MATCH, 5'd25);
        send_letter(sam_tb_pkg::KIND_MATCH, 5'd25);

        // random: mostly build text then walk it, some noise
        while (sent < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 9);
            if (r < 3)
                build_run($urandom_range(1, 40), ($urandom_range(0, 4) == 0) ? 26 :
                          $urandom_range(2, 4));
            else if (r < 8)
                match_run($urandom_range(1, 30));
            else
                send_letter(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
        end

        for (int i = 0; i < 40; i++)
            send_letter(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
        match_run(30);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("tb_suffix_automaton_substring_matcher_top: PASS");
        else
            $display("tb_suffix_automaton_substring_matcher_top: FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/sam_pkg.sv
hw/rtl/sam_ram.sv
hw/rtl/sam_ctrl.sv
hw/rtl/suffix_automaton_substring_matcher_top.sv
test/sam_tb_pkg.sv
test/sam_checker.sv
test/tb_suffix_automaton_substring_matcher_top.sv
